// ===== rtl/pe64_image_size_parser_assert.svh =====
// assertion macros shared by the image size parser modules
// no dependencies; each macro checks one property on the rising clock edge
`ifndef PE64_IMAGE_SIZE_PARSER_ASSERT_SVH
`define PE64_IMAGE_SIZE_PARSER_ASSERT_SVH

// condition implies consequence in the same cycle
`define PE64ISP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pe64isp: implication check failed");

// condition implies consequence in the next cycle
`define PE64ISP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pe64isp: next-cycle check failed");

`endif

// ===== rtl/pe64isp_pkg.sv =====
// shared types and constants of the image size parser
// no dependencies
`default_nettype none

package pe64isp_pkg;

    // byte position counter width, saturates at all ones
    localparam int POS_W = 33;

    // dos mark bytes, in stream order
    localparam logic [15:0] DOS_MARK = 16'h4D5A;
    localparam logic [7:0]  MZ_BYTE0 = DOS_MARK[15:8];
    localparam logic [7:0]  MZ_BYTE1 = DOS_MARK[7:0];

    // header offset field position and end
    localparam int LFANEW_AT = 'h3C;
    localparam int HDR_END   = LFANEW_AT + 4;

    // nt header contents
    localparam logic [31:0] NT_SIGNATURE  = {16'h5045, 16'h0000};
    localparam logic [15:0] MACHINE_AMD64 = 16'h8664;
    localparam logic [15:0] OPT_MAGIC64   = 16'h020B;

    // field offsets relative to the header offset
    localparam int FILE_HDR_SIZE    = 20;
    localparam int SIZE_OF_IMAGE_AT = 14 * 4;
    localparam int SIG_LEN          = 4;
    localparam int MACHINE_REL      = 4;
    localparam int MAGIC_REL        = MACHINE_REL + FILE_HDR_SIZE;
    localparam int SIZE_REL         = MAGIC_REL + SIZE_OF_IMAGE_AT;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_MZ     = 3'd1,
        ST_TRUNC     = 3'd2,
        ST_BAD_SIG   = 3'd3,
        ST_NOT_AMD64 = 3'd4,
        ST_BAD_MAGIC = 3'd5
    } status_t;

    // one finished buffer, handed from front to back
    typedef struct packed {
        logic             mz_ok;
        logic [POS_W-1:0] size;
        logic [31:0]      hdr;
        logic [31:0]      sig;
        logic [15:0]      mach;
        logic [15:0]      magic;
        logic [31:0]      soi;
    } desc_t;

endpackage

`default_nettype wire

// ===== rtl/pe64isp_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module pe64isp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/pe64isp_front.sv =====
// front end: byte intake, position count, field capture and prefix fetch
// depends on pe64isp_pkg, pe64isp_ram and the assertion macro header
`default_nettype none
`include "pe64_image_size_parser_assert.svh"

module pe64isp_front #(
    parameter int PREFIX_BYTES = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last,
    input  wire logic               byte_valid,
    output logic                    byte_stall,
    input  wire logic               q_full,
    output logic                    push,
    output pe64isp_pkg::desc_t      desc
);

    import pe64isp_pkg::*;

    localparam int AW = $clog2(PREFIX_BYTES);
    localparam int FW = AW + 1;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // fetch list: signature bytes, then machine, then magic
    localparam logic [2:0] FETCH_MACH_AT  = 3'd4;
    localparam logic [2:0] FETCH_MAGIC_AT = 3'd6;
    localparam logic [2:0] FETCH_LAST     = 3'd7;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       b0_reg, b0_next;
    logic             mz_ok_reg, mz_ok_next;
    logic [31:0]      hdr_reg, hdr_next;
    logic [31:0]      sig_reg, sig_next;
    logic [15:0]      mach_reg, mach_next;
    logic [15:0]      magic_reg, magic_next;
    logic [31:0]      soi_reg, soi_next;
    logic             pend_reg, pend_next;
    logic             fetch_active_reg, fetch_active_next;
    logic [2:0]       fetch_idx_reg, fetch_idx_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             rd_use_reg, rd_use_next;
    logic [2:0]       rd_idx_reg, rd_idx_next;

    logic             accept;
    logic             in_prefix;
    logic             in_lfanew;
    logic [1:0]       hdr_lane;
    logic             at_fetch_start;
    logic [POS_W:0]   diff;
    logic             rel_ok;
    logic [6:0]       rel;
    logic             push_direct;
    logic             push_pend;
    logic             h_small;
    logic [FW-1:0]    fetch_addr;
    logic             fetch_use;
    logic             wr_en;
    logic [7:0]       rd_data;

    function automatic logic [FW-1:0] fetch_offset(input logic [2:0] idx);
        logic [FW-1:0] off;
        if (idx < FETCH_MACH_AT)
        begin
            off = FW'(idx);
        end
        else if (idx < FETCH_MAGIC_AT)
        begin
            off = FW'(MACHINE_REL) + FW'(idx - FETCH_MACH_AT);
        end
        else
        begin
            off = FW'(MAGIC_REL) + FW'(idx - FETCH_MAGIC_AT);
        end
        return off;
    endfunction

    // handshake and position decode
    assign byte_stall     = q_full || pend_reg;
    assign accept         = byte_valid && !byte_stall;
    assign in_prefix      = pos_reg < POS_W'(PREFIX_BYTES);
    assign in_lfanew      = (pos_reg >= POS_W'(LFANEW_AT)) && (pos_reg < POS_W'(HDR_END));
    assign hdr_lane       = 2'(pos_reg - POS_W'(LFANEW_AT));
    assign at_fetch_start = pos_reg == POS_W'(PREFIX_BYTES - 1);

    // distance of the current byte from the header offset
    assign diff   = {1'b0, pos_reg} - {2'b00, hdr_reg};
    assign rel_ok = !diff[POS_W] && (diff[POS_W-1:7] == '0);
    assign rel    = diff[6:0];

    // prefix fetch address for the current list entry
    assign h_small    = hdr_reg[31:AW] == '0;
    assign fetch_addr = FW'(hdr_reg[AW-1:0]) + fetch_offset(fetch_idx_reg);
    assign fetch_use  = h_small && (fetch_addr < FW'(PREFIX_BYTES));

    // prefix store
    assign wr_en = accept && in_prefix;

    pe64isp_ram #(
        .WIDTH (8),
        .DEPTH (PREFIX_BYTES)
    ) u_prefix (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (pos_reg[AW-1:0]),
        .wr_data (data_byte),
        .rd_addr (fetch_addr[AW-1:0]),
        .rd_data (rd_data)
    );

    // byte capture and fetched byte merge
    always_comb
    begin
        pos_next   = pos_reg;
        b0_next    = b0_reg;
        mz_ok_next = mz_ok_reg;
        hdr_next   = hdr_reg;
        sig_next   = sig_reg;
        mach_next  = mach_reg;
        magic_next = magic_reg;
        soi_next   = soi_reg;
        if (accept)
        begin
            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
            if (in_prefix)
            begin
                if (pos_reg == '0)
                begin
                    b0_next = data_byte;
                end
                if (pos_reg == POS_W'(1))
                begin
                    mz_ok_next = (b0_reg == MZ_BYTE0) && (data_byte == MZ_BYTE1);
                end
                if (in_lfanew)
                begin
                    hdr_next[8*hdr_lane +: 8] = data_byte;
                end
            end
            else if (rel_ok)
            begin
                if (rel < 7'(SIG_LEN))
                begin
                    sig_next[8*rel[1:0] +: 8] = data_byte;
                end
                else if (rel >= 7'(MACHINE_REL) && rel < 7'(MACHINE_REL + 2))
                begin
                    mach_next[8*(1'(rel - 7'(MACHINE_REL))) +: 8] = data_byte;
                end
                else if (rel >= 7'(MAGIC_REL) && rel < 7'(MAGIC_REL + 2))
                begin
                    magic_next[8*(1'(rel - 7'(MAGIC_REL))) +: 8] = data_byte;
                end
                else if (rel >= 7'(SIZE_REL) && rel < 7'(SIZE_REL + 4))
                begin
                    soi_next[8*(2'(rel - 7'(SIZE_REL))) +: 8] = data_byte;
                end
            end
        end
        // fetched prefix byte lands in its field lane
        if (rd_pend_reg && rd_use_reg)
        begin
            if (rd_idx_reg < FETCH_MACH_AT)
            begin
                sig_next[8*rd_idx_reg[1:0] +: 8] = rd_data;
            end
            else if (rd_idx_reg < FETCH_MAGIC_AT)
            begin
                mach_next[8*rd_idx_reg[0] +: 8] = rd_data;
            end
            else
            begin
                magic_next[8*rd_idx_reg[0] +: 8] = rd_data;
            end
        end
    end

    // fetch sequencer, one prefix read per cycle
    always_comb
    begin
        fetch_active_next = fetch_active_reg;
        fetch_idx_next    = fetch_idx_reg;
        rd_pend_next      = 1'b0;
        rd_use_next       = rd_use_reg;
        rd_idx_next       = rd_idx_reg;
        if (fetch_active_reg)
        begin
            rd_pend_next   = 1'b1;
            rd_use_next    = fetch_use;
            rd_idx_next    = fetch_idx_reg;
            fetch_idx_next = fetch_idx_reg + 3'd1;
            if (fetch_idx_reg == FETCH_LAST)
            begin
                fetch_active_next = 1'b0;
            end
        end
        if (accept && at_fetch_start)
        begin
            fetch_active_next = 1'b1;
            fetch_idx_next    = '0;
        end
    end

    // end of buffer: hand over now or once the fetch is through
    assign push_direct = accept && last && !(at_fetch_start || fetch_active_reg);
    assign push_pend   = pend_reg && !fetch_active_reg && !q_full;
    assign push        = push_direct || push_pend;

    always_comb
    begin
        pend_next = pend_reg;
        if (accept && last && !push_direct)
        begin
            pend_next = 1'b1;
        end
        else if (push_pend)
        begin
            pend_next = 1'b0;
        end
    end

    always_comb
    begin
        desc.mz_ok = mz_ok_next;
        desc.size  = pos_next;
        desc.hdr   = hdr_next;
        desc.sig   = sig_next;
        desc.mach  = mach_next;
        desc.magic = magic_next;
        desc.soi   = soi_next;
    end

    // buffer state, cleared after each hand-over
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            b0_reg           <= '0;
            mz_ok_reg        <= 1'b0;
            hdr_reg          <= '0;
            sig_reg          <= '0;
            mach_reg         <= '0;
            magic_reg        <= '0;
            soi_reg          <= '0;
            pend_reg         <= 1'b0;
            fetch_active_reg <= 1'b0;
            fetch_idx_reg    <= '0;
            rd_pend_reg      <= 1'b0;
            rd_use_reg       <= 1'b0;
            rd_idx_reg       <= '0;
        end
        else
        begin
            if (push)
            begin
                pos_reg   <= '0;
                b0_reg    <= '0;
                mz_ok_reg <= 1'b0;
                hdr_reg   <= '0;
                sig_reg   <= '0;
                mach_reg  <= '0;
                magic_reg <= '0;
                soi_reg   <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                b0_reg    <= b0_next;
                mz_ok_reg <= mz_ok_next;
                hdr_reg   <= hdr_next;
                sig_reg   <= sig_next;
                mach_reg  <= mach_next;
                magic_reg <= magic_next;
                soi_reg   <= soi_next;
            end
            pend_reg         <= pend_next;
            fetch_active_reg <= fetch_active_next;
            fetch_idx_reg    <= fetch_idx_next;
            rd_pend_reg      <= rd_pend_next;
            rd_use_reg       <= rd_use_next;
            rd_idx_reg       <= rd_idx_next;
        end
    end

    // a buffer is handed over only with every prefix field byte merged
    `PE64ISP_ASSERT_IMPLIES(a_push_after_fetch, clk, rst_n, push, !fetch_active_reg)
    // the prefix is not overwritten while it is being read
    `PE64ISP_ASSERT_IMPLIES(a_no_write_in_fetch, clk, rst_n, fetch_active_reg, !wr_en)

endmodule

`default_nettype wire

// ===== rtl/pe64isp_fifo.sv =====
// short queue of finished buffers between front and back
// depends on the assertion macro header
`default_nettype none
`include "pe64_image_size_parser_assert.svh"

module pe64isp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full     = count_reg == CW'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `PE64ISP_ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, !full)
    `PE64ISP_ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop, !empty)

endmodule

`default_nettype wire

// ===== rtl/pe64isp_back.sv =====
// back end: header checks on a finished buffer and the result register
// depends on pe64isp_pkg and the assertion macro header
`default_nettype none
`include "pe64_image_size_parser_assert.svh"

module pe64isp_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pe64isp_pkg::desc_t  head,
    input  wire logic                q_empty,
    output logic                     q_pop,
    output pe64isp_pkg::status_t     status,
    output logic [31:0]              image_size,
    output logic                     result_valid,
    input  wire logic                result_stall
);

    import pe64isp_pkg::*;

    logic           result_valid_reg;
    status_t        status_reg, status_next;
    logic [31:0]    image_size_reg, image_size_next;
    logic [POS_W:0] span;
    logic [31:0]    sig_be;
    logic           report_failed;

    // true when a field of len bytes past the header offset runs off the end
    function automatic logic runs_past(input logic [POS_W:0] s, input int unsigned len);
        return s[POS_W] || (s[POS_W-1:0] < POS_W'(len));
    endfunction

    // bytes from the header offset to the end of the buffer
    assign span   = {1'b0, head.size} - {2'b00, head.hdr};
    assign sig_be = {head.sig[7:0], head.sig[15:8], head.sig[23:16], head.sig[31:24]};

    // checks in order, first failure wins
    always_comb
    begin
        status_next     = ST_OK;
        image_size_next = '0;
        if (!head.mz_ok)
        begin
            status_next = ST_NO_MZ;
        end
        else if (head.size < POS_W'(HDR_END) || runs_past(span, SIG_LEN))
        begin
            status_next = ST_TRUNC;
        end
        else if (sig_be != NT_SIGNATURE)
        begin
            status_next = ST_BAD_SIG;
        end
        else if (runs_past(span, MACHINE_REL + 2))
        begin
            status_next = ST_TRUNC;
        end
        else if (head.mach != MACHINE_AMD64)
        begin
            status_next = ST_NOT_AMD64;
        end
        else if (runs_past(span, MAGIC_REL + 2))
        begin
            status_next = ST_TRUNC;
        end
        else if (head.magic != OPT_MAGIC64)
        begin
            status_next = ST_BAD_MAGIC;
        end
        else if (runs_past(span, SIZE_REL + 4))
        begin
            status_next = ST_TRUNC;
        end
        else
        begin
            image_size_next = head.soi;
        end
    end

    // result register, refilled as the old item leaves
    assign q_pop = !q_empty && (!result_valid_reg || !result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (!result_valid_reg || !result_stall)
        begin
            result_valid_reg <= !q_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            status_reg     <= status_next;
            image_size_reg <= image_size_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign image_size   = image_size_reg;

    // failed buffer on the output
    assign report_failed = result_valid_reg && (status_reg != ST_OK);

    // a failed buffer never reports a size
    `PE64ISP_ASSERT_IMPLIES(a_fail_zero_size, clk, rst_n, report_failed, image_size_reg == '0)

endmodule

`default_nettype wire

// ===== rtl/pe64_image_size_parser.sv =====
// image size parser: byte items in, one status and size item per buffer out
// a buffer's result passes the queue, then the result register; when the buffer ends
// during the eight-read prefix fetch, hand-over waits for it to finish (input stalls)
// throughput: one byte per cycle except while the queue is full or a buffer is pending
// reset: rst_n async active low clears position, fields, queue and result valid
// depends on pe64isp_pkg, pe64isp_front, pe64isp_fifo and pe64isp_back
`default_nettype none

module pe64_image_size_parser #(
    parameter int PREFIX_BYTES = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 last,
    input  wire logic                 byte_valid,
    output logic                      byte_stall,
    output pe64isp_pkg::status_t      status,
    output logic [31:0]               image_size,
    output logic                      result_valid,
    input  wire logic                 result_stall
);

    import pe64isp_pkg::*;

    desc_t push_desc;
    desc_t head_desc;
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;

    // intake and field capture
    pe64isp_front #(
        .PREFIX_BYTES (PREFIX_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .last       (last),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .q_full     (q_full),
        .push       (q_push),
        .desc       (push_desc)
    );

    // finished buffers waiting for evaluation
    pe64isp_fifo #(
        .WIDTH ($bits(desc_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_desc),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (head_desc),
        .empty     (q_empty)
    );

    // checks and result register
    pe64isp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_desc),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .status       (status),
        .image_size   (image_size),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

`default_nettype wire

// ===== test/tb_pe64_image_size_parser.sv =====
// testbench for pe64_image_size_parser: byte streams of executable images, status and size
// checked against a cycle-free predictor of the header walk; depends on pe64isp_pkg
`timescale 1ns / 100ps

module tb_pe64_image_size_parser;

    import pe64isp_pkg::*;

    localparam int PREFIX_BYTES = 64;
    localparam int ITEM_GOAL    = 650;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int MISS_SHOWN   = 10;
    localparam logic [63:0] POS_MAX = (64'd1 << POS_W) - 64'd1;
    // signature bytes in stream order, packed little-endian
    localparam logic [31:0] SIG_STREAM = {NT_SIGNATURE[7:0], NT_SIGNATURE[15:8],
                                          NT_SIGNATURE[23:16], NT_SIGNATURE[31:24]};

    typedef struct packed {
        logic [7:0] data;
        logic       eob;
    } stream_byte_t;

    typedef struct {
        status_t     st;
        logic [31:0] img_size;
    } size_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [7:0]  data_byte = 8'd0;
    logic        last = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    status_t     status;
    logic [31:0] image_size;
    logic        result_valid;
    logic        result_stall = 1'b0;

    stream_byte_t stream_q[$];
    size_report_t size_reports_due[$];
    logic [7:0]   image_bytes[$];

    int bytes_queued = 0;
    int bytes_offered = 0;
    int bytes_taken = 0;
    int pressure_mark = 0;
    int miss_count = 0;
    int cycle_count = 0;

    // predictor state, one buffer at a time
    logic [63:0] pos_count = '0;
    logic [7:0]  prefix_mem [PREFIX_BYTES];
    logic [31:0] hdr_offset = '0;
    logic [31:0] sig_w = '0;
    logic [31:0] mach_w = '0;
    logic [31:0] magic_w = '0;
    logic [31:0] soi_w = '0;

    pe64_image_size_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_byte    (data_byte),
        .last         (last),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .status       (status),
        .image_size   (image_size),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // drop byte b into a field word when position p falls inside the field
    function automatic logic [31:0] merge_field(input logic [31:0] w, input logic [63:0] base,
                                                input int n, input logic [63:0] p,
                                                input logic [7:0] b);
        logic [31:0] r;
        r = w;
        if (p >= base && p - base < n)
            r[8*int'(p - base) +: 8] = b;
        return r;
    endfunction

    // byte k of a field at position at: from the prefix store or the captured word
    function automatic logic [7:0] field_at(input logic [63:0] at, input logic [31:0] w,
                                            input int k);
        if (at < PREFIX_BYTES)
            return prefix_mem[at[5:0]];
        return w[8*(k%4) +: 8];
    endfunction

    // header walk at the end of a buffer of len bytes
    function automatic size_report_t judge_image(input logic [63:0] len);
        logic [63:0]  h;
        logic [31:0]  sigv;
        size_report_t r;
        h = {32'd0, hdr_offset};
        r.st = ST_OK;
        r.img_size = '0;
        sigv = {field_at(h, sig_w, 0), field_at(h + 1, sig_w, 1),
                field_at(h + 2, sig_w, 2), field_at(h + 3, sig_w, 3)};
        if (len < 2 || {prefix_mem[0], prefix_mem[1]} != DOS_MARK)
            r.st = ST_NO_MZ;
        else if (HDR_END > len || h + SIG_LEN > len)
            r.st = ST_TRUNC;
        else if (sigv != NT_SIGNATURE)
            r.st = ST_BAD_SIG;
        else if (h + MACHINE_REL + 2 > len)
            r.st = ST_TRUNC;
        else if ({field_at(h + MACHINE_REL + 1, mach_w, 1),
                  field_at(h + MACHINE_REL, mach_w, 0)} != MACHINE_AMD64)
            r.st = ST_NOT_AMD64;
        else if (h + MAGIC_REL + 2 > len)
            r.st = ST_TRUNC;
        else if ({field_at(h + MAGIC_REL + 1, magic_w, 1),
                  field_at(h + MAGIC_REL, magic_w, 0)} != OPT_MAGIC64)
            r.st = ST_BAD_MAGIC;
        else if (h + SIZE_REL + 4 > len)
            r.st = ST_TRUNC;
        else
            r.img_size = {field_at(h + SIZE_REL + 3, soi_w, 3), field_at(h + SIZE_REL + 2, soi_w, 2),
                          field_at(h + SIZE_REL + 1, soi_w, 1), field_at(h + SIZE_REL, soi_w, 0)};
        return r;
    endfunction

    // one accepted byte: store or capture, count, and on the last byte report
    task automatic image_predict_byte(input logic [7:0] b, input logic eob);
        logic [63:0] p;
        logic [63:0] h;
        p = pos_count;
        h = {32'd0, hdr_offset};
        if (p < PREFIX_BYTES)
        begin
            prefix_mem[p[5:0]] = b;
            hdr_offset = merge_field(hdr_offset, LFANEW_AT, 4, p, b);
        end
        else
        begin
            sig_w   = merge_field(sig_w, h, SIG_LEN, p, b);
            mach_w  = merge_field(mach_w, h + MACHINE_REL, 2, p, b);
            magic_w = merge_field(magic_w, h + MAGIC_REL, 2, p, b);
            soi_w   = merge_field(soi_w, h + SIZE_REL, 4, p, b);
        end
        if (pos_count < POS_MAX)
            pos_count = pos_count + 1;
        if (eob)
        begin
            size_reports_due.push_back(judge_image(pos_count));
            pos_count  = '0;
            hdr_offset = '0;
            sig_w      = '0;
            mach_w     = '0;
            magic_w    = '0;
            soi_w      = '0;
        end
    endtask

    // ---------------------------------------------------------------- image builders

    task automatic start_image(input int n);
        image_bytes.delete();
        repeat (n)
            image_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // little-endian write, clipped at the end of the buffer
    task automatic put_le(input logic [63:0] at, input logic [31:0] v, input int n);
        for (int k = 0; k < n; k++)
            if (at + k < image_bytes.size())
                image_bytes[at + k] = v[8*k +: 8];
    endtask

    // random buffer with mark, offset and header fields laid in
    task automatic make_header(input logic [63:0] hdr, input logic [15:0] mach,
                               input logic [15:0] magic, input logic [31:0] soi, input int len);
        start_image(len);
        put_le(hdr, SIG_STREAM, SIG_LEN);
        put_le(hdr + MACHINE_REL, {16'd0, mach}, 2);
        put_le(hdr + MAGIC_REL, {16'd0, magic}, 2);
        put_le(hdr + SIZE_REL, soi, 4);
        put_le(0, {16'd0, MZ_BYTE1, MZ_BYTE0}, 2);
        put_le(LFANEW_AT, hdr[31:0], 4);
    endtask

    task automatic flip_bit(input logic [63:0] at);
        if (at < image_bytes.size())
            image_bytes[at] = image_bytes[at] ^ (8'd1 << $urandom_range(0, 7));
    endtask

    task automatic queue_image();
        stream_byte_t sb;
        foreach (image_bytes[i])
        begin
            sb.data = image_bytes[i];
            sb.eob  = (i == image_bytes.size() - 1);
            stream_q.push_back(sb);
        end
        bytes_queued += image_bytes.size();
    endtask

    // ---------------------------------------------------------------- stimulus and end

    initial
    begin
        int          sel;
        int          pick;
        int          img_len;
        int          random_goal;
        logic [31:0] hdr_at;
        longint      full;

        foreach (prefix_mem[i])
            prefix_mem[i] = '0;

        // lone bytes and two-byte buffers
        start_image(1);
        image_bytes[0] = 8'hFF;
        queue_image();
        start_image(1);
        image_bytes[0] = MZ_BYTE0;
        queue_image();
        start_image(2);
        put_le(0, {16'd0, MZ_BYTE1, MZ_BYTE0}, 2);
        queue_image();
        start_image(2);
        put_le(0, {16'd0, MZ_BYTE0, MZ_BYTE1}, 2);
        queue_image();

        // mark present but the offset is cut off
        make_header(4, MACHINE_AMD64, OPT_MAGIC64, $urandom, 63);
        queue_image();

        // good image, header straddling the prefix end, size at its maximum
        make_header(40, MACHINE_AMD64, OPT_MAGIC64, 32'hFFFF_FFFF, 124);
        queue_image();

        // bad signature past the prefix
        make_header(64, MACHINE_AMD64, OPT_MAGIC64, $urandom, 68);
        flip_bit(64 + $urandom_range(0, 3));
        queue_image();
        // wrong machine read from the prefix
        make_header(4, 16'h014C, OPT_MAGIC64, $urandom, 64);
        queue_image();

        // magic cut off at the first byte past the prefix
        make_header(40, MACHINE_AMD64, OPT_MAGIC64, $urandom, 65);
        queue_image();
        // offset far past any buffer
        make_header(64'hFFFF_FFFC, MACHINE_AMD64, OPT_MAGIC64, $urandom, 64);
        queue_image();

        // burst of tiny buffers, sent while the receiver holds off
        pressure_mark = bytes_queued;
        random_goal = ITEM_GOAL;
        repeat (20)
        begin
            start_image($urandom_range(1, 3));
            if ($urandom_range(0, 1))
                put_le(0, {16'd0, MZ_BYTE1, MZ_BYTE0}, 2);
            queue_image();
        end

        // mostly well-formed headers with random faults, some noise
        while (bytes_queued < random_goal)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 15)
            begin
                start_image(sel < 8 ? $urandom_range(1, 3) : $urandom_range(4, 90));
                if ($urandom_range(0, 1))
                    put_le(0, {16'd0, MZ_BYTE1, MZ_BYTE0}, 2);
            end
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    hdr_at = $urandom_range(4, 63);
                else if (pick < 8)
                    hdr_at = $urandom_range(64, 100);
                else if (pick == 8)
                    hdr_at = $urandom_range(0, 3);
                else
                    hdr_at = $urandom | 32'h8000_0000;
                full = longint'(hdr_at) + SIZE_REL + 4;
                if (pick == 9)
                    img_len = $urandom_range(60, 100);
                else if ($urandom_range(0, 3) == 0)
                    img_len = $urandom_range(2, int'(full) - 1);
                else
                    img_len = int'(full) + $urandom_range(0, 6);
                make_header({32'd0, hdr_at}, MACHINE_AMD64, OPT_MAGIC64, $urandom, img_len);
                case ($urandom_range(0, 7))
                    0: flip_bit($urandom_range(0, 1));
                    1: flip_bit({32'd0, hdr_at} + $urandom_range(0, 3));
                    2: flip_bit({32'd0, hdr_at} + MACHINE_REL + $urandom_range(0, 1));
                    3: flip_bit({32'd0, hdr_at} + MAGIC_REL + $urandom_range(0, 1));
                    default: ;
                endcase
            end
            queue_image();
        end

        // reset
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for every byte taken and every report back
        while (stream_q.size() != 0 || (byte_valid && bytes_taken < bytes_offered)
               || size_reports_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (miss_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // ---------------------------------------------------------------- byte driver

    // bursts of random length with random gaps; holds the item until taken
    always @(negedge clk)
    begin
        stream_byte_t sb;
        logic         nxt_valid;
        int           burst_left;
        int           gap_left;
        if (rst_n && !(byte_valid && bytes_taken < bytes_offered))
        begin
            nxt_valid = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (stream_q.size() != 0)
            begin
                sb = stream_q.pop_front();
                data_byte <= sb.data;
                last      <= sb.eob;
                nxt_valid = 1'b1;
                bytes_offered++;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            byte_valid <= nxt_valid;
        end
    end

    // ---------------------------------------------------------------- result receiver

    // segments of random stall density, plus one long hold once the tiny buffers start
    always @(negedge clk)
    begin
        logic stall_nxt;
        int   hold_left;
        bit   hold_done;
        int   seg_left;
        int   stall_pct;
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                stall_nxt = 1'b1;
            end
            else if (!hold_done && bytes_taken >= pressure_mark)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                stall_nxt = 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(5, 60);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        2: stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                seg_left--;
                stall_nxt = ($urandom_range(0, 99) < stall_pct);
            end
            result_stall <= stall_nxt;
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge clk)
    begin
        size_report_t due;
        if (rst_n)
        begin
            // input side feeds the predictor
            if (byte_valid && !byte_stall)
            begin
                bytes_taken++;
                image_predict_byte(data_byte, last);
            end
            // output side against the oldest report due
            if (result_valid && !result_stall)
            begin
                if (size_reports_due.size() == 0)
                begin
                    miss_count++;
                    if (miss_count <= MISS_SHOWN)
                        $display("unexpected report: status %0d image_size %h",
                                 status, image_size);
                end
                else
                begin
                    due = size_reports_due.pop_front();
                    if (status !== due.st || image_size !== due.img_size)
                    begin
                        miss_count++;
                        if (miss_count <= MISS_SHOWN)
                            $display("mismatch: status exp %0d got %0d, image_size exp %h got %h",
                                     due.st, status, due.img_size, image_size);
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
